// File: sv/indexed_list_insert_erase_top_defines.svh
// Assertion macros used by the checker of the indexed list engine.
`ifndef INDEXED_LIST_INSERT_ERASE_TOP_DEFINES_SVH
`define INDEXED_LIST_INSERT_ERASE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ILIE_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ILIE_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ilie_pkg.sv
package ilie_pkg;

    localparam int CAPACITY      = 256;
    localparam int DATA_WIDTH    = 32;

    localparam int CMD_W         = 3;
    localparam int INDEX_W       = 8;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int COUNT_FIELD_W = 9;

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (COUNT_W > COUNT_FIELD_W) ? COUNT_W : COUNT_FIELD_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ    = 3'd0,
        CMD_APPEND  = 3'd1,
        CMD_INSERT  = 3'd2,
        CMD_ERASE   = 3'd3,
        CMD_REPLACE = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RD_WAIT,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_LOAD_COUNT,
        PTR_LOAD_INDEX,
        PTR_INC,
        PTR_DEC
    } ptr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        WA_PTR,
        WA_COUNT,
        WA_INDEX
    } waddr_sel_t;

    typedef enum logic [1:0] {
        RA_INDEX,
        RA_PTR_DOWN,
        RA_PTR_UP
    } raddr_sel_t;

    typedef enum logic {
        WD_VALUE,
        WD_RDATA
    } wdata_sel_t;

    typedef struct packed {
        logic       load_item;
        ptr_op_t    ptr_op;
        cnt_op_t    cnt_op;
        logic       ram_we;
        waddr_sel_t waddr_sel;
        wdata_sel_t wdata_sel;
        raddr_sel_t raddr_sel;
        logic       status_load;
        status_t    status_code;
        logic       capture_read;
        logic       out_load;
    } dp_ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             idx_lt_count;
        logic             idx_le_count;
        logic             list_full;
        logic             ptr_at_index;
        logic             ptr_at_last;
    } dp_stat_t;

    // Fit the 32-bit value field to the stored word width.
    function automatic logic [DATA_WIDTH-1:0] to_store(input logic [VALUE_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[DATA_WIDTH-1:0];
    endfunction

    // Fit a stored word back to the 32-bit result field.
    function automatic logic [VALUE_W-1:0] to_field(input logic [DATA_WIDTH-1:0] d);
        logic [63:0] w;
        w = 64'(d);
        return w[VALUE_W-1:0];
    endfunction

endpackage

// File: sv/ilie_ram.sv
module ilie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/ilie_ctrl.sv
module ilie_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  ilie_pkg::dp_stat_t stat,
    output ilie_pkg::dp_ctrl_t ctrl
);
    import ilie_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        ctrl       = '0;
        state_next = state_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load_item = 1'b1;
                    state_next     = S_DECODE;
                end
            end

            S_DECODE:
            begin
                ctrl.status_load = 1'b1;
                ctrl.status_code = ST_OK;
                state_next       = S_FINISH;
                case (stat.cmd)
                    CMD_READ:
                    begin
                        if (stat.idx_lt_count)
                        begin
                            ctrl.raddr_sel = RA_INDEX;
                            state_next     = S_RD_WAIT;
                        end
                        else
                        begin
                            ctrl.status_code = ST_RANGE;
                        end
                    end
                    CMD_APPEND:
                    begin
                        if (stat.list_full)
                        begin
                            ctrl.status_code = ST_FULL;
                        end
                        else
                        begin
                            ctrl.ram_we    = 1'b1;
                            ctrl.waddr_sel = WA_COUNT;
                            ctrl.wdata_sel = WD_VALUE;
                            ctrl.cnt_op    = CNT_INC;
                        end
                    end
                    CMD_INSERT:
                    begin
                        if (!stat.idx_le_count)
                        begin
                            ctrl.status_code = ST_RANGE;
                        end
                        else if (stat.list_full)
                        begin
                            ctrl.status_code = ST_FULL;
                        end
                        else
                        begin
                            ctrl.ptr_op = PTR_LOAD_COUNT;
                            state_next  = S_SHIFT_RD;
                        end
                    end
                    CMD_ERASE:
                    begin
                        if (stat.idx_lt_count)
                        begin
                            ctrl.ptr_op = PTR_LOAD_INDEX;
                            state_next  = S_SHIFT_RD;
                        end
                        else
                        begin
                            ctrl.status_code = ST_RANGE;
                        end
                    end
                    CMD_REPLACE:
                    begin
                        if (stat.idx_lt_count)
                        begin
                            ctrl.ram_we    = 1'b1;
                            ctrl.waddr_sel = WA_INDEX;
                            ctrl.wdata_sel = WD_VALUE;
                        end
                        else
                        begin
                            ctrl.status_code = ST_RANGE;
                        end
                    end
                    default:
                    begin
                        ctrl.status_code = ST_OK;
                    end
                endcase
            end

            S_SHIFT_RD:
            begin
                if (stat.cmd == CMD_INSERT)
                begin
                    if (stat.ptr_at_index)
                    begin
                        ctrl.ram_we    = 1'b1;
                        ctrl.waddr_sel = WA_PTR;
                        ctrl.wdata_sel = WD_VALUE;
                        ctrl.cnt_op    = CNT_INC;
                        state_next     = S_FINISH;
                    end
                    else
                    begin
                        ctrl.raddr_sel = RA_PTR_DOWN;
                        state_next     = S_SHIFT_WR;
                    end
                end
                else
                begin
                    if (stat.ptr_at_last)
                    begin
                        ctrl.cnt_op = CNT_DEC;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        ctrl.raddr_sel = RA_PTR_UP;
                        state_next     = S_SHIFT_WR;
                    end
                end
            end

            S_SHIFT_WR:
            begin
                ctrl.ram_we    = 1'b1;
                ctrl.waddr_sel = WA_PTR;
                ctrl.wdata_sel = WD_RDATA;
                ctrl.ptr_op    = (stat.cmd == CMD_INSERT) ? PTR_DEC : PTR_INC;
                state_next     = S_SHIFT_RD;
            end

            S_RD_WAIT:
            begin
                ctrl.capture_read = 1'b1;
                state_next        = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: sv/ilie_dp.sv
module ilie_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [ilie_pkg::CMD_W-1:0]          cmd,
    input  logic [ilie_pkg::INDEX_W-1:0]        index,
    input  logic signed [ilie_pkg::VALUE_W-1:0] value,
    input  ilie_pkg::dp_ctrl_t                  ctrl,
    output ilie_pkg::dp_stat_t                  stat,
    output logic signed [ilie_pkg::VALUE_W-1:0] read_value,
    output logic [ilie_pkg::STATUS_W-1:0]       status,
    output logic [ilie_pkg::COUNT_FIELD_W-1:0]  count
);
    import ilie_pkg::*;

    logic [CMD_W-1:0]         cmd_reg;
    logic [INDEX_W-1:0]       index_reg;
    logic [VALUE_W-1:0]       value_reg;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic [COUNT_W-1:0]       ptr_reg, ptr_next;
    logic [STATUS_W-1:0]      status_reg;
    logic [VALUE_W-1:0]       res_value_reg;
    logic [VALUE_W-1:0]       read_value_reg;
    logic [STATUS_W-1:0]      status_out_reg;
    logic [COUNT_FIELD_W-1:0] count_out_reg;

    logic [CMP_W-1:0]      idx_ext, cnt_ext, ptr_ext;
    logic [COUNT_W-1:0]    ptr_dn, ptr_up;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

    assign idx_ext = CMP_W'(index_reg);
    assign cnt_ext = CMP_W'(count_reg);
    assign ptr_ext = CMP_W'(ptr_reg);
    assign ptr_dn  = ptr_reg - COUNT_W'(1);
    assign ptr_up  = ptr_reg + COUNT_W'(1);

    assign stat.cmd          = cmd_reg;
    assign stat.idx_lt_count = (idx_ext < cnt_ext);
    assign stat.idx_le_count = (idx_ext <= cnt_ext);
    assign stat.list_full    = (count_reg == COUNT_W'(CAPACITY));
    assign stat.ptr_at_index = (ptr_ext == idx_ext);
    assign stat.ptr_at_last  = ((ptr_ext + CMP_W'(1)) == cnt_ext);

    always_comb
    begin
        case (ctrl.ptr_op)
            PTR_LOAD_COUNT: ptr_next = count_reg;
            PTR_LOAD_INDEX: ptr_next = idx_ext[COUNT_W-1:0];
            PTR_INC:        ptr_next = ptr_up;
            PTR_DEC:        ptr_next = ptr_dn;
            default:        ptr_next = ptr_reg;
        endcase

        case (ctrl.cnt_op)
            CNT_INC: count_next = count_reg + COUNT_W'(1);
            CNT_DEC: count_next = count_reg - COUNT_W'(1);
            default: count_next = count_reg;
        endcase

        case (ctrl.waddr_sel)
            WA_COUNT: ram_waddr = count_reg[ADDR_W-1:0];
            WA_INDEX: ram_waddr = idx_ext[ADDR_W-1:0];
            default:  ram_waddr = ptr_reg[ADDR_W-1:0];
        endcase

        case (ctrl.raddr_sel)
            RA_PTR_DOWN: ram_raddr = ptr_dn[ADDR_W-1:0];
            RA_PTR_UP:   ram_raddr = ptr_up[ADDR_W-1:0];
            default:     ram_raddr = idx_ext[ADDR_W-1:0];
        endcase

        ram_wdata = (ctrl.wdata_sel == WD_RDATA) ? ram_rdata : to_store(value_reg);
        ram_we    = ctrl.ram_we;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            cmd_reg       <= cmd;
            index_reg     <= index;
            value_reg     <= value;
            res_value_reg <= '0;
        end
        else if (ctrl.capture_read)
        begin
            res_value_reg <= to_field(ram_rdata);
        end
        if (ctrl.status_load)
        begin
            status_reg <= ctrl.status_code;
        end
        if (ctrl.out_load)
        begin
            read_value_reg <= res_value_reg;
            status_out_reg <= status_reg;
            count_out_reg  <= cnt_ext[COUNT_FIELD_W-1:0];
        end
    end

    ilie_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign read_value = read_value_reg;
    assign status     = status_out_reg;
    assign count      = count_out_reg;

endmodule

// File: sv/indexed_list_insert_erase_top.sv
// Indexed list engine: an ordered list of up to 256 signed 32-bit words held in a
// single-port-write, registered-read RAM. One command beat is taken at a time and
// answered with exactly one result beat (read value, status, count). Insert and
// erase move the entries behind the index one place through the RAM, each by a
// read in S_SHIFT_RD and a write of the read word in S_SHIFT_WR. The result
// register frees the input side: a new command is taken while the last result
// still waits, and the engine holds a finished result only if the previous one
// was not yet taken. No clearing pass after reset: the count is zeroed and
// entries at or above it are never read.
module indexed_list_insert_erase_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ilie_pkg::CMD_W-1:0]          cmd,
    input  logic [ilie_pkg::INDEX_W-1:0]        index,
    input  logic signed [ilie_pkg::VALUE_W-1:0] value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ilie_pkg::VALUE_W-1:0] read_value,
    output logic [ilie_pkg::STATUS_W-1:0]       status,
    output logic [ilie_pkg::COUNT_FIELD_W-1:0]  count
);
    import ilie_pkg::*;

    // Command and status buses between the sequencer and the list datapath.
    dp_ctrl_t ctrl;
    dp_stat_t stat;

    // Sequencer: decode the command, walk the shift loop, hold the result beat.
    ilie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // Datapath: command registers, count and shift pointer, element RAM and
    // the result register that drives the output payload.
    ilie_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .index      (index),
        .value      (value),
        .ctrl       (ctrl),
        .stat       (stat),
        .read_value (read_value),
        .status     (status),
        .count      (count)
    );

endmodule

// File: sv/ilie_checker.sv
`include "indexed_list_insert_erase_top_defines.svh"

module ilie_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic [ilie_pkg::CMD_W-1:0]          cmd,
    input logic [ilie_pkg::INDEX_W-1:0]        index,
    input logic signed [ilie_pkg::VALUE_W-1:0] value,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [ilie_pkg::VALUE_W-1:0] read_value,
    input logic [ilie_pkg::STATUS_W-1:0]       status,
    input logic [ilie_pkg::COUNT_FIELD_W-1:0]  count
);
    import ilie_pkg::*;

    `ILIE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(read_value) && $stable(status) && $stable(count), "stalled result beat changed or dropped")
    `ILIE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "second command taken before the first finished")
    `ILIE_ASSERT_SAME(a_range_zero, clk, rst_n, out_valid && (status == ST_RANGE), read_value == '0, "range error with nonzero read value")
    `ILIE_ASSERT_SAME(a_full_count, clk, rst_n, out_valid && (status == ST_FULL), count == COUNT_FIELD_W'(CAPACITY), "full status with count below capacity")

endmodule

bind indexed_list_insert_erase_top ilie_checker u_ilie_checker (.*);

// File: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ilie_pkg::*;

    // Command codes above CMD_REPLACE are undefined: they must leave the list alone.
    localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

    // Quiet cycles tolerated before declaring the engine hung. The slowest legal
    // command is an insert at the head of a 255-entry list, and the receiver
    // hold-off below comes on top of that.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AT_RESULT = 300;
    localparam int RANDOM_BEATS = 1150;
    localparam int FULL_LIST_BEATS = 40;
    localparam int DRAIN_FLOOR = 8;
    localparam int MAX_PRINTED_MISMATCHES = 50;

    typedef struct {
        logic [CMD_W-1:0]          op;
        logic [INDEX_W-1:0]        idx;
        logic signed [VALUE_W-1:0] val;
    } list_cmd_t;

    typedef struct {
        logic signed [VALUE_W-1:0]  read_value;
        status_t                    status;
        logic [COUNT_FIELD_W-1:0]   count;
    } list_result_t;

    // How the random stream steers the list length.
    typedef enum {
        GROW_TO_FULL,
        HOLD_AT_FULL,
        DRAIN,
        BALANCED
    } list_phase_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [CMD_W-1:0]            cmd = '0;
    logic [INDEX_W-1:0]          index = '0;
    logic signed [VALUE_W-1:0]   value = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [VALUE_W-1:0]   read_value;
    logic [STATUS_W-1:0]         status;
    logic [COUNT_FIELD_W-1:0]    count;

    // Shadow copy of the list, advanced once per accepted command beat.
    logic signed [VALUE_W-1:0]   list_words [CAPACITY];
    int unsigned                 list_len = 0;

    list_cmd_t                   pending_cmds [$];
    list_result_t                expected_results [$];

    int unsigned                 cmds_pushed = 0;
    int unsigned                 cmds_accepted = 0;
    int unsigned                 results_seen = 0;
    int unsigned                 mismatch_count = 0;
    int unsigned                 quiet_cycles = 0;
    int unsigned                 hold_left = 0;
    bit                          hold_done = 1'b0;

    indexed_list_insert_erase_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .index      (index),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .status     (status),
        .count      (count)
    );

    always #2 clk = ~clk;

    // Apply one command to the shadow list and return the result it must produce.
    // Insert moves entries at and above the index up one place, erase moves the
    // entries above the index down one place. Every failure leaves the list as is.
    function automatic list_result_t predict_list_result(input list_cmd_t c);
        list_result_t r;
        int unsigned  pos;
        r.read_value = '0;
        r.status     = ST_OK;
        case (c.op)
            CMD_READ:
                if (c.idx < list_len) r.read_value = list_words[c.idx];
                else r.status = ST_RANGE;
            CMD_APPEND:
                // The index field plays no part: the word lands at the tail.
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    list_words[list_len] = c.val;
                    list_len++;
                end
            CMD_INSERT:
                // The range test wins over the full test.
                if (c.idx > list_len)
                    r.status = ST_RANGE;
                else if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (pos = list_len; pos > c.idx; pos--)
                        list_words[pos] = list_words[pos - 1];
                    list_words[c.idx] = c.val;
                    list_len++;
                end
            CMD_ERASE:
                if (c.idx < list_len)
                begin
                    for (pos = c.idx; pos + 1 < list_len; pos++)
                        list_words[pos] = list_words[pos + 1];
                    list_len--;
                end
                else
                    r.status = ST_RANGE;
            CMD_REPLACE:
                if (c.idx < list_len) list_words[c.idx] = c.val;
                else r.status = ST_RANGE;
            default:
                ;
        endcase
        r.count = COUNT_FIELD_W'(list_len);
        return r;
    endfunction

    // Draw one random command. grow_pct steers append/insert against erase;
    // most indexes are legal for the current length, the rest span the field.
    function automatic list_cmd_t random_list_cmd(input int unsigned grow_pct);
        list_cmd_t   c;
        int unsigned len;
        int unsigned roll;
        len  = list_len;
        roll = $urandom_range(99);
        if (roll < 3)
            c.op = CMD_UNDEF_LO + CMD_W'($urandom_range(CMD_UNDEF_HI - CMD_UNDEF_LO));
        else if (roll < 18)
            c.op = CMD_READ;
        else if (roll < 33)
            c.op = CMD_REPLACE;
        else if ($urandom_range(99) < grow_pct)
            c.op = $urandom_range(1) ? CMD_APPEND : CMD_INSERT;
        else
            c.op = CMD_ERASE;

        if ($urandom_range(99) < 15 || c.op == CMD_APPEND)
            c.idx = INDEX_W'($urandom_range(255));
        else if (c.op == CMD_INSERT)
            c.idx = INDEX_W'((len >= CAPACITY) ? $urandom_range(255) : $urandom_range(len));
        else
            c.idx = INDEX_W'((len == 0) ? 0 : $urandom_range(len - 1));

        case ($urandom_range(15))
            0: c.val = 32'sh7fffffff;
            1: c.val = 32'sh80000000;
            2: c.val = '0;
            3: c.val = '1;
            default: c.val = $urandom;
        endcase
        return c;
    endfunction

    task automatic push_cmd(input logic [CMD_W-1:0] op, input logic [INDEX_W-1:0] idx,
                            input logic signed [VALUE_W-1:0] val);
        list_cmd_t c;
        c.op  = op;
        c.idx = idx;
        c.val = val;
        pending_cmds.push_back(c);
        cmds_pushed++;
    endtask

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        if (mismatch_count < MAX_PRINTED_MISMATCHES)
            $display("[%0t] result %0d: %s mismatch, got %h want %h",
                     $realtime, results_seen, what, got, want);
        mismatch_count++;
    endtask

    // Idle schedule: light sender gaps with a slow receiver, then the reverse,
    // then both sides at full rate.
    function automatic int unsigned sender_idle_pct();
        if (cmds_accepted < 350) return 9;
        if (cmds_accepted < 700) return 79;
        return 0;
    endfunction

    function automatic int unsigned receiver_idle_pct();
        if (cmds_accepted < 350) return 79;
        if (cmds_accepted < 700) return 9;
        return 0;
    endfunction

    // Command driver: predict on every accepted beat, hold a stalled beat as is,
    // otherwise offer the next pending command or idle for this cycle.
    always @(posedge clk or negedge rst_n)
    begin : drive_cmds
        list_cmd_t next_cmd;
        list_cmd_t taken;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd      <= '0;
            index    <= '0;
            value    <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                taken.op  = cmd;
                taken.idx = index;
                taken.val = value;
                expected_results.push_back(predict_list_result(taken));
                cmds_accepted++;
            end
            // A stalled beat stays on the bus untouched.
            if (!in_valid || !in_stall)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct())
                begin
                    next_cmd = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    cmd      <= next_cmd.op;
                    index    <= next_cmd.idx;
                    value    <= next_cmd.val;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each accepted beat against the oldest prediction,
    // then pick the stall for the next cycle. Once, hold the output off for a
    // long stretch so the engine backs up and stalls its command input.
    always @(posedge clk or negedge rst_n)
    begin : check_results
        list_result_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected beat", read_value, '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (read_value !== want.read_value)
                        report_mismatch("read_value", read_value, want.read_value);
                    if (status !== want.status)
                        report_mismatch("status", VALUE_W'(status), VALUE_W'(want.status));
                    if (count !== want.count)
                        report_mismatch("count", VALUE_W'(count), VALUE_W'(want.count));
                end
            end

            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (!hold_done && results_seen >= HOLD_OFF_AT_RESULT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < receiver_idle_pct());
        end
    end

    // Watchdog: any accepted beat on either side resets the quiet count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] no beat accepted for %0d cycles", $realtime, quiet_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin : run_stimulus
        list_cmd_t   c;
        list_phase_t phase;
        int unsigned n;
        int unsigned full_beats;

        repeat (3) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Directed: every range error on the empty list, build a small list from the
        // value extremes, then hit head, middle and tail, out-of-range indexes
        // and the undefined codes.
        push_cmd(CMD_READ,    8'd0,   32'sh11111111);
        push_cmd(CMD_ERASE,   8'd0,   '0);
        push_cmd(CMD_REPLACE, 8'd0,   32'sh22222222);
        push_cmd(CMD_INSERT,  8'd1,   32'sh33333333);
        push_cmd(CMD_INSERT,  8'd0,   32'sh7fffffff);
        push_cmd(CMD_APPEND,  8'd255, 32'sh80000000);
        push_cmd(CMD_INSERT,  8'd2,   '1);
        push_cmd(CMD_INSERT,  8'd0,   '0);
        push_cmd(CMD_INSERT,  8'd2,   32'sh5a5a5a5a);
        push_cmd(CMD_READ,    8'd0,   '1);
        push_cmd(CMD_READ,    8'd4,   '0);
        push_cmd(CMD_READ,    8'd5,   '0);
        push_cmd(CMD_READ,    8'd255, '0);
        push_cmd(CMD_REPLACE, 8'd1,   32'sh12345678);
        push_cmd(CMD_REPLACE, 8'd5,   32'sh0badf00d);
        push_cmd(CMD_ERASE,   8'd255, '0);
        push_cmd(CMD_ERASE,   8'd4,   '0);
        push_cmd(CMD_ERASE,   8'd0,   '0);
        push_cmd(CMD_ERASE,   8'd1,   '0);
        push_cmd(CMD_UNDEF_LO,                  8'd0,   32'sh7fffffff);
        push_cmd(CMD_UNDEF_LO + CMD_W'(1),      8'd255, '1);
        push_cmd(CMD_UNDEF_HI,                  8'd1,   32'sh80000000);
        push_cmd(CMD_READ,    8'd0,   '0);
        push_cmd(CMD_READ,    8'd1,   '0);
        push_cmd(CMD_INSERT,  8'd3,   32'sh44444444);

        // Pause the sender until every queued command has been answered.
        while (results_seen < cmds_pushed)
            @(posedge clk);
        repeat (8) @(posedge clk);

        // Random: grow to capacity, hammer the full list, drain to a few
        // entries, then let the length wander.
        phase      = GROW_TO_FULL;
        full_beats = 0;
        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            // Keep the queue short so index choices track the real length.
            while (pending_cmds.size() >= 2)
                @(posedge clk);
            case (phase)
                GROW_TO_FULL:
                    if (list_len >= CAPACITY) phase = HOLD_AT_FULL;
                HOLD_AT_FULL:
                    if (full_beats >= FULL_LIST_BEATS) phase = DRAIN;
                DRAIN:
                    if (list_len <= DRAIN_FLOOR) phase = BALANCED;
                default:
                    ;
            endcase
            case (phase)
                GROW_TO_FULL: c = random_list_cmd(95);
                HOLD_AT_FULL:
                begin
                    c = random_list_cmd(90);
                    full_beats++;
                end
                DRAIN:        c = random_list_cmd(8);
                default:      c = random_list_cmd(50);
            endcase
            pending_cmds.push_back(c);
            cmds_pushed++;
        end

        // Drain: everything sent, everything answered, then watch for strays.
        while (results_seen < cmds_pushed)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
